// ===== rtl/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants for the periodic task release scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int TASKS_DEFAULT       = 8;
    localparam int COUNT_WIDTH_DEFAULT = 16;

    localparam int KIND_W     = 3;
    localparam int SLOT_W     = 8;
    localparam int FIELD_W    = 16;
    localparam int INDEX_W    = 6;
    localparam int PRESCALE_W = 8;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    // register indexes (word address)
    localparam logic REG_TICKS_PER_EVENT_GROUP = 1'b0;

    localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 8'd1;
    localparam logic [PRESCALE_W-1:0] TICKS_RESET    = 8'd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_TIMER   = 3'd0,
        KIND_CREATE  = 3'd1,
        KIND_SUSPEND = 3'd2,
        KIND_RESUME  = 3'd3,
        KIND_DELETE  = 3'd4
    } kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic  tick;
        logic  shift;
        logic  cmd_en;
        kind_t kind;
    } cell_ctrl_t;

endpackage

// ===== rtl/pts_cell.sv =====
// ----------------------------------------------------------------------------
// pts_cell
// One task slot: marks, period, countdown and a release flag that shifts
// toward the head of the chain during a scan.
// ----------------------------------------------------------------------------
module pts_cell #(
    parameter int COUNT_WIDTH = pts_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pts_pkg::cell_ctrl_t          ctrl,
    input  logic                         sel,
    input  logic [pts_pkg::FIELD_W-1:0]  period,
    input  logic [pts_pkg::FIELD_W-1:0]  first_delay,
    input  logic                         pend_in,
    output logic                         pend_out
);

    logic                   valid_reg,   valid_next;
    logic                   running_reg, running_next;
    logic [COUNT_WIDTH-1:0] period_reg,  period_next;
    logic [COUNT_WIDTH-1:0] count_reg,   count_next;
    logic                   pend_reg,    pend_next;

    logic [31:0] period_ext;
    logic [31:0] delay_ext;

    assign period_ext = {16'd0, period};
    assign delay_ext  = {16'd0, first_delay};

    always_comb
    begin
        valid_next   = valid_reg;
        running_next = running_reg;
        period_next  = period_reg;
        count_next   = count_reg;
        pend_next    = pend_reg;

        if (ctrl.tick)
        begin
            pend_next = 1'b0;
            if (running_reg)
            begin
                if (count_reg == '0)
                begin
                    // a running but deleted slot just holds at zero
                    if (valid_reg)
                    begin
                        pend_next  = 1'b1;
                        count_next = period_reg - 1'b1;
                    end
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
        end
        else if (ctrl.shift)
        begin
            pend_next = pend_in;
        end
        else if (ctrl.cmd_en && sel)
        begin
            unique case (ctrl.kind)
                pts_pkg::KIND_CREATE:
                begin
                    if (!valid_reg)
                    begin
                        valid_next   = 1'b1;
                        running_next = 1'b1;
                        period_next  = period_ext[COUNT_WIDTH-1:0];
                        count_next   = delay_ext[COUNT_WIDTH-1:0];
                    end
                end
                pts_pkg::KIND_SUSPEND: running_next = 1'b0;
                pts_pkg::KIND_RESUME:  running_next = 1'b1;
                pts_pkg::KIND_DELETE:  valid_next   = 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            running_reg <= 1'b0;
            period_reg  <= '0;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            running_reg <= running_next;
            period_reg  <= period_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
        end
    end

    assign pend_out = pend_reg;

endmodule

// ===== rtl/periodic_task_release_scheduler.sv =====
// ----------------------------------------------------------------------------
// periodic_task_release_scheduler
// Time-triggered scheduler: a chain of task slot cells, a prescaler and an
// APB register for the events per tick.
// ----------------------------------------------------------------------------
// a command or a timer event that does not end a tick gives its one result in
//   the cycle after it is accepted; one request per cycle when idle, unstalled
// a tick: all cells update in the accept cycle, then the release flags shift
//   out one slot per cycle while the output is free, then a closing result
//   follows; no new request is taken until that closing result is issued
// reset clears all slot marks and counters at once; the prescaler resets to 1
module periodic_task_release_scheduler #(
    parameter int TASKS       = pts_pkg::TASKS_DEFAULT,
    parameter int COUNT_WIDTH = pts_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pts_pkg::ADDR_W-1:0]      paddr,
    input  logic [pts_pkg::DATA_W-1:0]      pwdata,
    output logic [pts_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [pts_pkg::KIND_W-1:0]      kind,
    input  logic [pts_pkg::SLOT_W-1:0]      slot,
    input  logic [pts_pkg::FIELD_W-1:0]     period,
    input  logic [pts_pkg::FIELD_W-1:0]     first_delay,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pts_pkg::INDEX_W-1:0]     task_index,
    output logic                            fired,
    output logic                            status,
    output logic                            last
);

    localparam int SCAN_W = $clog2(TASKS + 1);

    pts_pkg::state_t state_reg, state_next;

    logic [SCAN_W-1:0]                 scan_reg, scan_next;
    logic [pts_pkg::PRESCALE_W-1:0]    ticks_reg;
    logic [pts_pkg::PRESCALE_W-1:0]    prescale_reg, prescale_next;
    logic [pts_pkg::PRESCALE_W-1:0]    prescale_dec;

    logic                              out_valid_reg;
    logic [pts_pkg::INDEX_W-1:0]       task_index_reg;
    logic                              fired_reg;
    logic                              status_reg;
    logic                              last_reg;

    logic                              out_free;
    logic                              accept;
    logic                              is_timer;
    logic                              tick_now;
    logic                              in_range;
    logic                              emit;
    logic [pts_pkg::INDEX_W-1:0]       emit_index;
    logic                              emit_fired;
    logic                              emit_status;
    logic                              emit_last;
    pts_pkg::cell_ctrl_t               ctrl;
    pts_pkg::kind_t                    kind_code;
    logic [TASKS:0]                    pend_chain;
    logic                              cfg_write;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == pts_pkg::REG_TICKS_PER_EVENT_GROUP)
                       ? {24'd0, ticks_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ticks_reg <= pts_pkg::TICKS_RESET;
        else if (cfg_write && paddr[2] == pts_pkg::REG_TICKS_PER_EVENT_GROUP)
            ticks_reg <= pwdata[pts_pkg::PRESCALE_W-1:0];
    end

    assign out_free     = !out_valid_reg || out_ready;
    assign kind_code    = pts_pkg::kind_t'(kind);
    assign is_timer     = (kind_code == pts_pkg::KIND_TIMER);
    assign in_range     = (slot < pts_pkg::SLOT_W'(TASKS));
    assign prescale_dec = prescale_reg - 1'b1;
    assign accept       = in_valid && in_ready;
    assign tick_now     = accept && is_timer && (prescale_dec == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        unique case (state_reg)
            pts_pkg::ST_IDLE:
            begin
                if (tick_now)
                begin
                    state_next = pts_pkg::ST_SCAN;
                    scan_next  = '0;
                end
            end
            pts_pkg::ST_SCAN:
            begin
                if (out_free)
                begin
                    if (scan_reg == SCAN_W'(TASKS))
                        state_next = pts_pkg::ST_IDLE;
                    else
                        scan_next = scan_reg + 1'b1;
                end
            end
            default: state_next = pts_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready    = 1'b0;
        emit        = 1'b0;
        emit_index  = '0;
        emit_fired  = 1'b0;
        emit_status = 1'b0;
        emit_last   = 1'b1;
        ctrl.tick   = 1'b0;
        ctrl.shift  = 1'b0;
        ctrl.cmd_en = 1'b0;
        ctrl.kind   = kind_code;
        unique case (state_reg)
            pts_pkg::ST_IDLE:
            begin
                in_ready = out_free;
                if (accept)
                begin
                    if (is_timer)
                    begin
                        ctrl.tick = tick_now;
                        emit      = !tick_now;
                    end
                    else
                    begin
                        emit = 1'b1;
                        if (kind > pts_pkg::KIND_W'(pts_pkg::KIND_DELETE))
                            emit_status = 1'b0;
                        else if (!in_range)
                            emit_status = 1'b1;
                        else
                            ctrl.cmd_en = 1'b1;
                    end
                end
            end
            pts_pkg::ST_SCAN:
            begin
                if (out_free)
                begin
                    if (scan_reg == SCAN_W'(TASKS))
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        // head of the chain belongs to slot scan_reg
                        ctrl.shift = 1'b1;
                        emit       = pend_chain[0];
                        emit_index = pts_pkg::INDEX_W'(scan_reg);
                        emit_fired = 1'b1;
                        emit_last  = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        prescale_next = prescale_reg;
        if (accept && is_timer)
            prescale_next = (prescale_dec == '0) ? ticks_reg : prescale_dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pts_pkg::ST_IDLE;
            scan_reg      <= '0;
            prescale_reg  <= pts_pkg::PRESCALE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_reg     <= scan_next;
            prescale_reg <= prescale_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            task_index_reg <= emit_index;
            fired_reg      <= emit_fired;
            status_reg     <= emit_status;
            last_reg       <= emit_last;
        end
    end

    assign pend_chain[TASKS] = 1'b0;

    for (genvar i = 0; i < TASKS; i++)
    begin : g_cell
        pts_cell #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .sel         (slot == pts_pkg::SLOT_W'(i)),
            .period      (period),
            .first_delay (first_delay),
            .pend_in     (pend_chain[i+1]),
            .pend_out    (pend_chain[i])
        );
    end

    assign out_valid  = out_valid_reg;
    assign task_index = task_index_reg;
    assign fired      = fired_reg;
    assign status     = status_reg;
    assign last       = last_reg;

endmodule

// ===== rtl/pts_checker.sv =====
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks on the result stream of the task release scheduler.
// ----------------------------------------------------------------------------
module pts_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_ready,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [pts_pkg::INDEX_W-1:0]  task_index,
    input  logic                         fired,
    input  logic                         status,
    input  logic                         last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(task_index) && $stable(fired)
            && $stable(last))
        else $error("stalled result changed");

    // no new request while a result is stuck
    a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken while output stalled");

    // a release is never the closing result and never an error
    a_fired_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fired |-> !last && !status)
        else $error("release result malformed");

    // an out-of-range answer is a single closing result
    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> last && !fired && task_index == '0)
        else $error("error result malformed");

endmodule

bind periodic_task_release_scheduler pts_checker u_pts_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .task_index (task_index),
    .fired      (fired),
    .status     (status),
    .last       (last)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the periodic task release scheduler. A queue of
// task commands and timer events feeds a valid/ready driver; a slot table
// kept here predicts every release and closing result, and a monitor checks
// each result in order. Both sides idle at random; the events-per-tick
// register is rewritten between phases over its full span.
// ----------------------------------------------------------------------------
module testbench;

    localparam int N_SLOTS    = pts_pkg::TASKS_DEFAULT;
    localparam int CNT_W      = pts_pkg::COUNT_WIDTH_DEFAULT;
    localparam int KIND_W     = pts_pkg::KIND_W;
    localparam int SLOT_W     = pts_pkg::SLOT_W;
    localparam int FIELD_W    = pts_pkg::FIELD_W;
    localparam int INDEX_W    = pts_pkg::INDEX_W;
    localparam int PRESCALE_W = pts_pkg::PRESCALE_W;
    localparam int ADDR_W     = pts_pkg::ADDR_W;
    localparam int DATA_W     = pts_pkg::DATA_W;
    localparam int MAX_GAP  = 13;
    localparam int LONG_HOLD_AT     = 60;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int SETTLE_CYCLES    = N_SLOTS + 6;
    localparam int WATCHDOG_LIMIT   = 2000;

    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;
    localparam logic [ADDR_W-1:0] TICKS_ADDR     =
        {pts_pkg::REG_TICKS_PER_EVENT_GROUP, 2'b00};

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SLOT_W-1:0]  slot;
        logic [FIELD_W-1:0] period;
        logic [FIELD_W-1:0] first_delay;
    } request_t;

    typedef struct packed {
        logic [INDEX_W-1:0] task_index;
        logic               fired;
        logic               status;
        logic               last;
    } release_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic [KIND_W-1:0]   kind        = '0;
    logic [SLOT_W-1:0]   slot        = '0;
    logic [FIELD_W-1:0]  period      = '0;
    logic [FIELD_W-1:0]  first_delay = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic [INDEX_W-1:0]  task_index;
    logic                fired;
    logic                status;
    logic                last;

    // scheduler state as predicted here
    bit                  sched_valid[N_SLOTS];
    bit                  sched_running[N_SLOTS];
    logic [CNT_W-1:0]    sched_period[N_SLOTS]    = '{default: '0};
    logic [CNT_W-1:0]    sched_countdown[N_SLOTS] = '{default: '0};
    logic [PRESCALE_W-1:0] sched_prescale = pts_pkg::PRESCALE_RESET;
    logic [PRESCALE_W-1:0] sched_ticks    = pts_pkg::TICKS_RESET;

    request_t    pending_requests[$];
    release_t    expected_releases[$];
    request_t    next_req;
    release_t    want;
    bit          calm = 1'b0;
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    int unsigned recv_wait;
    int unsigned results_seen = 0;
    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;

    periodic_task_release_scheduler #(
        .TASKS       (N_SLOTS),
        .COUNT_WIDTH (CNT_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .slot        (slot),
        .period      (period),
        .first_delay (first_delay),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .task_index  (task_index),
        .fired       (fired),
        .status      (status),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic int unsigned draw_gap();
        if (calm || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // one request in, its releases and its closing result out
    function automatic void predict_releases(input request_t r);
        release_t rel;
        release_t hit;
        int       i;
        int       s;
        rel = '0;
        rel.last = 1'b1;
        s = int'(r.slot);
        if (r.kind == pts_pkg::KIND_TIMER)
        begin
            sched_prescale = sched_prescale - 8'd1;
            if (sched_prescale == '0)
            begin
                sched_prescale = sched_ticks;
                for (i = 0; i < N_SLOTS; i++)
                begin
                    if (sched_running[i])
                    begin
                        if (sched_countdown[i] != '0)
                            sched_countdown[i] = sched_countdown[i] - 1'b1;
                        else if (sched_valid[i])
                        begin
                            hit = '0;
                            hit.task_index = i[INDEX_W-1:0];
                            hit.fired = 1'b1;
                            expected_releases.push_back(hit);
                            sched_countdown[i] = sched_period[i] - 1'b1;
                        end
                    end
                end
            end
        end
        else if (r.kind <= pts_pkg::KIND_DELETE)
        begin
            if (s >= N_SLOTS)
                rel.status = 1'b1;
            else
            begin
                case (r.kind)
                    pts_pkg::KIND_CREATE:
                    begin
                        if (!sched_valid[s])
                        begin
                            sched_valid[s]     = 1'b1;
                            sched_running[s]   = 1'b1;
                            sched_period[s]    = r.period[CNT_W-1:0];
                            sched_countdown[s] = r.first_delay[CNT_W-1:0];
                        end
                    end
                    pts_pkg::KIND_SUSPEND: sched_running[s] = 1'b0;
                    pts_pkg::KIND_RESUME:  sched_running[s] = 1'b1;
                    default:               sched_valid[s]   = 1'b0;
                endcase
            end
        end
        expected_releases.push_back(rel);
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_releases(request_t'{kind, slot, period, first_delay});
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    next_req = pending_requests.pop_front();
                    kind        <= next_req.kind;
                    slot        <= next_req.slot;
                    period      <= next_req.period;
                    first_delay <= next_req.first_delay;
                    in_valid    <= 1'b1;
                    send_gap    <= draw_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap  <= 0;
        end
        else if (out_valid && out_ready)
        begin
            if (expected_releases.size() == 0)
                report_mismatch($sformatf("result with none expected: index %0d fired %b status %b last %b",
                                          task_index, fired, status, last));
            else
            begin
                want = expected_releases.pop_front();
                if (task_index !== want.task_index || fired !== want.fired ||
                    status !== want.status || last !== want.last)
                    report_mismatch($sformatf("got index %0d fired %b status %b last %b, want %0d %b %b %b",
                                              task_index, fired, status, last,
                                              want.task_index, want.fired, want.status, want.last));
            end
            results_seen++;
            // one long hold-off so the block backs up and stalls its input
            recv_wait = (results_seen == LONG_HOLD_AT) ? LONG_HOLD_CYCLES : draw_gap();
            recv_gap  <= recv_wait;
            out_ready <= (recv_wait == 0);
        end
        else if (recv_gap != 0)
        begin
            recv_gap  <= recv_gap - 1;
            out_ready <= (recv_gap == 1);
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    task automatic write_ticks(input logic [PRESCALE_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TICKS_ADDR;
        pwdata  <= {{(DATA_W-PRESCALE_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sched_ticks = value;
        // read it back
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {{(DATA_W-PRESCALE_W){1'b0}}, value})
            report_mismatch($sformatf("register read %0h, want %0h", prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_releases.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void post(input logic [KIND_W-1:0] k, input logic [SLOT_W-1:0] s,
                                 input logic [FIELD_W-1:0] p, input logic [FIELD_W-1:0] d);
        pending_requests.push_back(request_t'{k, s, p, d});
    endfunction

    // mostly small counts so slots fire often, now and then full range
    function automatic logic [FIELD_W-1:0] pick_count();
        int unsigned w;
        w = $urandom_range(0, 9);
        if (w < 6)
            return FIELD_W'($urandom_range(0, 4));
        if (w < 8)
            return FIELD_W'($urandom_range(0, 16'hFFFF));
        return (w == 8) ? 16'hFFFF : 16'h0000;
    endfunction

    function automatic request_t random_request(input int unsigned timer_pct);
        request_t    r;
        int unsigned w;
        w = $urandom_range(0, 99);
        if (w < timer_pct)
            r.kind = pts_pkg::KIND_TIMER;
        else
        begin
            w = $urandom_range(0, 19);
            if (w < 7)
                r.kind = pts_pkg::KIND_CREATE;
            else if (w < 10)
                r.kind = pts_pkg::KIND_SUSPEND;
            else if (w < 13)
                r.kind = pts_pkg::KIND_RESUME;
            else if (w < 18)
                r.kind = pts_pkg::KIND_DELETE;
            else
                r.kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        end
        if ($urandom_range(0, 7) == 0)
            r.slot = SLOT_W'($urandom_range(N_SLOTS, 255));
        else
            r.slot = SLOT_W'($urandom_range(0, N_SLOTS - 1));
        r.period      = pick_count();
        r.first_delay = pick_count();
        return r;
    endfunction

    task automatic run_phase(input logic [PRESCALE_W-1:0] ticks, input int count,
                             input int unsigned timer_pct, input bit no_gaps);
        int n;
        write_ticks(ticks);
        calm = no_gaps;
        for (n = 0; n < count; n++)
            pending_requests.push_back(random_request(timer_pct));
        wait_drained();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        write_ticks(8'd1);
        // every slot due at once: full tick of releases
        post(pts_pkg::KIND_CREATE, 0, 1, 0);
        post(pts_pkg::KIND_CREATE, 1, 1, 0);
        post(pts_pkg::KIND_CREATE, 2, 1, 0);
        post(pts_pkg::KIND_CREATE, 3, 1, 0);
        post(pts_pkg::KIND_CREATE, 4, 1, 0);
        post(pts_pkg::KIND_CREATE, 5, 1, 0);
        post(pts_pkg::KIND_CREATE, 6, 0, 0);          // period zero reloads all ones
        post(pts_pkg::KIND_CREATE, 7, 16'hFFFF, 0);
        post(pts_pkg::KIND_TIMER, 0, 0, 0);
        post(pts_pkg::KIND_CREATE, 3, 5, 5);          // occupied slot stays as is
        post(pts_pkg::KIND_CREATE, 8, 1, 1);          // out of range
        post(pts_pkg::KIND_SUSPEND, 8'hFF, 16'hFFFF, 16'hFFFF);
        post(KIND_UNUSED_LO, 8'hFF, 0, 0);            // unknown kinds answer ok
        post(KIND_UNUSED_LO + 3'd1, 3, 0, 0);
        post(KIND_UNUSED_HI, 0, 16'hFFFF, 16'hFFFF);
        post(pts_pkg::KIND_SUSPEND, 1, 0, 0);
        post(pts_pkg::KIND_DELETE, 2, 0, 0);          // zero countdown, not valid: held
        post(pts_pkg::KIND_DELETE, 6, 0, 0);          // still running, keeps counting
        post(pts_pkg::KIND_TIMER, 8'hFF, 16'hFFFF, 16'hFFFF);
        post(pts_pkg::KIND_RESUME, 1, 0, 0);
        post(pts_pkg::KIND_RESUME, 8, 0, 0);
        post(pts_pkg::KIND_CREATE, 2, 2, 16'hFFFF);   // free again after delete
        post(pts_pkg::KIND_TIMER, 0, 0, 0);
        post(pts_pkg::KIND_DELETE, 9, 0, 0);
        post(pts_pkg::KIND_CREATE, 8'hFF, 16'hFFFF, 16'hFFFF);
        wait_drained();

        run_phase(8'd3, 45, 45, 1'b0);
        run_phase(PRESCALE_W'($urandom_range(2, 16)), 45, 45, 1'b0);
        run_phase(8'd1, 40, 45, 1'b1);
        // reload of zero: no tick until the prescaler wraps
        run_phase(8'd0, 30, 97, 1'b0);
        run_phase(8'd255, 25, 97, 1'b0);

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
